// File: hw/rtl/ufxd_pkg.sv
// ----------------------------------------------------------------------------
// ufxd_pkg
// Shared widths, constants and types for the UART frame deframer.
// ----------------------------------------------------------------------------
package ufxd_pkg;

  // Width of one serial byte
  localparam int unsigned ByteW = 8;

  // Width of the frame position field on the result channel
  localparam int unsigned PosOutW = 6;

  // Header byte that carries the payload length
  localparam int unsigned LengthPos = 3;

  typedef logic [ByteW-1:0]   byte_t;
  typedef logic [PosOutW-1:0] pos_out_t;

  // One result item
  typedef struct packed {
    byte_t    data_byte;
    pos_out_t frame_position;
    logic     frame_end;
    logic     checksum_good;
    logic     length_error;
  } res_t;

endpackage

// File: hw/rtl/ufxd_if.sv
// ----------------------------------------------------------------------------
// ufxd_if
// Valid/ready channels of the deframer: received bytes in, results out.
// ----------------------------------------------------------------------------
interface ufxd_rx_if
  import ufxd_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ufxd_res_if
  import ufxd_pkg::*;
();
  logic     valid;
  logic     ready;
  byte_t    data_byte;
  pos_out_t frame_position;
  logic     frame_end;
  logic     checksum_good;
  logic     length_error;

  modport source (
    output valid, output data_byte, output frame_position,
    output frame_end, output checksum_good, output length_error,
    input ready
  );
  modport sink (
    input valid, input data_byte, input frame_position,
    input frame_end, input checksum_good, input length_error,
    output ready
  );
endinterface

// File: hw/rtl/uart_frame_xor_deframer_unit.sv
// ----------------------------------------------------------------------------
// uart_frame_xor_deframer_unit
// Splits a received byte stream into length-prefixed frames with XOR check.
// ----------------------------------------------------------------------------
// Output: each result is registered and is valid in the cycle after its byte transfer.
// Throughput: one byte per cycle; the result register is refilled in the
//   same cycle it is drained, so input ready only drops while a result
//   waits and the sink is not ready.
// Reset: rst_ni clears the frame counter, latched length, running XOR and
//   the result valid flag; the first byte after reset is frame position 0.
// ----------------------------------------------------------------------------
module uart_frame_xor_deframer_unit
  import ufxd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = 4,   // 4 .. 8
  parameter int unsigned MAX_PAYLOAD  = 32   // 1 .. 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ufxd_rx_if.sink     rx_i,
  ufxd_res_if.source  res_o
);

  // The frame counter must reach the checksum position of a full frame.
  localparam int unsigned PosW = $clog2(HEADER_BYTES + MAX_PAYLOAD + 1);
  // Compare width for position against header plus latched length.
  localparam int unsigned CmpW = (PosW > ByteW) ? PosW : ByteW;

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  logic [PosW-1:0] pos_q, pos_d;     // position of the next byte
  byte_t           len_q, len_d;     // payload length from the length byte
  byte_t           xor_q, xor_d;     // XOR of the frame's bytes so far

  // Result register
  logic valid_q, valid_d;
  res_t res_q, res_d;

  logic rx_xfer;
  logic pos_in_body;
  logic is_end;
  logic is_len_byte;
  logic len_err;
  logic [PosW+PosOutW-1:0] pos_wide;

  // Ready while the result slot is empty or being drained this cycle.
  assign rx_i.ready = !valid_q || res_o.ready;
  assign rx_xfer    = rx_i.valid && rx_i.ready;

  // --------------------------------------------------------------------------
  // Byte classification
  // --------------------------------------------------------------------------
  // The checksum byte sits right after the header and the payload. The
  // latched length never exceeds MAX_PAYLOAD, so the sum cannot wrap.
  assign pos_in_body = pos_q >= PosW'(HEADER_BYTES);
  assign is_end      = pos_in_body &&
                       (CmpW'(pos_q) == CmpW'(HEADER_BYTES) + CmpW'(len_q));
  assign is_len_byte = pos_q == PosW'(LengthPos);
  // Oversized length drops the frame right away.
  assign len_err     = !is_end && is_len_byte && (rx_i.rx_byte > ByteW'(MAX_PAYLOAD));

  // Position is reported modulo 64.
  assign pos_wide = (PosW + PosOutW)'(pos_q);

  // --------------------------------------------------------------------------
  // Next state and result
  // --------------------------------------------------------------------------
  always_comb begin
    pos_d   = pos_q;
    len_d   = len_q;
    xor_d   = xor_q;
    valid_d = valid_q;
    res_d   = res_q;

    if (res_o.ready) begin
      valid_d = 1'b0;
    end

    if (rx_xfer) begin
      valid_d              = 1'b1;
      res_d.data_byte      = rx_i.rx_byte;
      res_d.frame_position = pos_wide[PosOutW-1:0];
      res_d.frame_end      = is_end;
      res_d.checksum_good  = is_end && (rx_i.rx_byte == xor_q);
      res_d.length_error   = len_err;

      if (is_end || len_err) begin
        // restart: next byte opens a new frame
        pos_d = '0;
        xor_d = '0;
      end else begin
        if (is_len_byte) begin
          len_d = rx_i.rx_byte;
        end
        xor_d = xor_q ^ rx_i.rx_byte;
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      len_q   <= '0;
      xor_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      len_q   <= len_d;
      xor_q   <= xor_d;
      valid_q <= valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // --------------------------------------------------------------------------
  // Result channel
  // --------------------------------------------------------------------------
  assign res_o.valid          = valid_q;
  assign res_o.data_byte      = res_q.data_byte;
  assign res_o.frame_position = res_q.frame_position;
  assign res_o.frame_end      = res_q.frame_end;
  assign res_o.checksum_good  = res_q.checksum_good;
  assign res_o.length_error   = res_q.length_error;

endmodule

// File: hw/rtl/ufxd_checker.sv
// ----------------------------------------------------------------------------
// ufxd_checker
// Port-level assertions for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module ufxd_checker
  import ufxd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input byte_t    data_byte_i,
  input pos_out_t frame_position_i,
  input logic     frame_end_i,
  input logic     checksum_good_i,
  input logic     length_error_i
);

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(data_byte_i) && $stable(frame_position_i) &&
      $stable(frame_end_i) && $stable(checksum_good_i) && $stable(length_error_i))
    else $error("stalled result changed");

  // A good checksum only ever comes with frame end.
  a_good_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && checksum_good_i |-> frame_end_i)
    else $error("checksum_good without frame_end");

  // A length error is only raised on the length byte and never closes a frame.
  a_len_err_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && length_error_i |->
      !frame_end_i && (frame_position_i == PosOutW'(LengthPos)))
    else $error("length_error off the length byte");

  // Each byte transfer yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("byte transfer without result");

  // After a closed or dropped frame, the next result opens at position 0.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && (frame_end_i || length_error_i) ##1 out_valid_i
      |-> frame_position_i == '0)
    else $error("frame did not restart at position 0");

endmodule

bind uart_frame_xor_deframer_unit ufxd_checker u_ufxd_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (rx_i.valid),
  .in_ready_i       (rx_i.ready),
  .out_valid_i      (res_o.valid),
  .out_ready_i      (res_o.ready),
  .data_byte_i      (res_o.data_byte),
  .frame_position_i (res_o.frame_position),
  .frame_end_i      (res_o.frame_end),
  .checksum_good_i  (res_o.checksum_good),
  .length_error_i   (res_o.length_error)
);
